>>> design/cmt_pkg.sv
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared types, constants and helpers for the CAN mailbox table.
// ----------------------------------------------------------------------------
package cmt_pkg;

  localparam int SLOTS         = 8;
  localparam int PAYLOAD_BYTES = 8;

  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ADDR_W  = SLOT_W + 1;
  localparam int ENTRIES = 1 << ADDR_W;

  localparam int ID_W      = 11;
  localparam int LEN_W     = 8;
  localparam int LINK_W    = 2;
  localparam int DATA_W    = 64;
  localparam int FLEN_W    = 4;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 88;

  localparam logic [ID_W-1:0]  RX_FIRST  = 11'h0B1;
  localparam logic [ID_W-1:0]  TX_FIRST  = 11'h0C1;
  localparam logic [LEN_W-1:0] FRAME_MAX = 8'd8;

  localparam logic [LINK_W-1:0] LINK_CAN1 = 2'd0;
  localparam logic [LINK_W-1:0] LINK_CAN2 = 2'd1;

  typedef enum logic [1:0] {
    REQ_STORE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_SWEEP = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    KIND_STORE_ACK  = 3'd0,
    KIND_READ_REPLY = 3'd1,
    KIND_CLEAR_ACK  = 3'd2,
    KIND_FRAME      = 3'd3,
    KIND_SWEEP_END  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD_ID = 2'd1,
    ST_SHORT  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SW_ADDR,
    S_SW_EMIT,
    S_SW_END
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic store_wr;
    logic clear_wr;
    logic sweep_sel;
    logic cnt_clear;
    logic cnt_inc;
    logic load_ack;
    logic load_read;
    logic load_frame;
    logic load_end;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_t req;
    logic eligible;
    logic cnt_last;
    logic out_free;
  } stat_t;

  // Keeps the first n bytes, never more than the payload size.
  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < DATA_W / 8; i++) begin
      m[8*i +: 8] = ((i < PAYLOAD_BYTES) && (LEN_W'(i) < n)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

>>> design/cmt_ram.sv
// ----------------------------------------------------------------------------
// cmt_ram
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module cmt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/cmt_ctrl.sv
// ----------------------------------------------------------------------------
// cmt_ctrl
// Sequencer for store, read, clear and transmit sweep requests.
// ----------------------------------------------------------------------------
module cmt_ctrl
  import cmt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.latch = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.req)
          REQ_STORE: begin
            if (stat.out_free) begin
              ctrl.store_wr = 1'b1;
              ctrl.load_ack = 1'b1;
              state_next    = S_IDLE;
            end
          end
          REQ_CLEAR: begin
            if (stat.out_free) begin
              ctrl.clear_wr = 1'b1;
              ctrl.load_ack = 1'b1;
              state_next    = S_IDLE;
            end
          end
          REQ_READ: begin
            state_next = S_READ;
          end
          REQ_SWEEP: begin
            ctrl.cnt_clear = 1'b1;
            state_next     = S_SW_ADDR;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_READ: begin
        if (stat.out_free) begin
          ctrl.load_read = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_SW_ADDR: begin
        ctrl.sweep_sel = 1'b1;
        state_next     = S_SW_EMIT;
      end
      S_SW_EMIT: begin
        ctrl.sweep_sel = 1'b1;
        // A slot that is not sent moves on at once; a sent one waits for room.
        if (!stat.eligible || stat.out_free) begin
          ctrl.load_frame = stat.eligible;
          if (stat.cnt_last) begin
            state_next = S_SW_END;
          end else begin
            ctrl.cnt_inc = 1'b1;
            state_next   = S_SW_ADDR;
          end
        end
      end
      S_SW_END: begin
        if (stat.out_free) begin
          ctrl.load_end = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> design/cmt_datapath.sv
// ----------------------------------------------------------------------------
// cmt_datapath
// Request register, slot tables, byte RAM and the output word register.
// ----------------------------------------------------------------------------
module cmt_datapath
  import cmt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_t                  ctrl,
  output stat_t                  stat,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [2:0]             out_tuser,
  output logic                   out_last
);

  // Latched request
  req_t              req_q;
  logic [ID_W-1:0]   id_q;
  logic [LEN_W-1:0]  msg_len_q;
  logic [LINK_W-1:0] link_q;
  logic [DATA_W-1:0] payload_q;

  // Slot tables, receive bank in the lower half, transmit bank in the upper
  logic [LEN_W-1:0]  slot_len  [ENTRIES];
  logic [LINK_W-1:0] slot_link [ENTRIES];

  logic [SLOT_W-1:0] cnt;
  logic [ID_W-1:0]   tx_off;
  logic [ID_W-1:0]   rx_off;
  logic              is_tx;
  logic              is_rx;
  logic              id_ok;
  logic [ADDR_W-1:0] addr;
  logic [LEN_W-1:0]  cur_len;
  logic [LINK_W-1:0] cur_link;
  logic [DATA_W-1:0] ram_q;
  logic              ram_wr;
  logic              read_ok;

  // Output word register
  kind_t             out_kind;
  status_t           out_status;
  logic [ID_W-1:0]   out_fid;
  logic [FLEN_W-1:0] out_flen;
  logic              out_bus;
  logic [DATA_W-1:0] out_data;

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      req_q     <= req_t'(in_tuser);
      id_q      <= in_tdata[10:0];
      msg_len_q <= in_tdata[18:11];
      link_q    <= in_tdata[20:19];
      payload_q <= in_tdata[84:21];
    end
  end

  assign tx_off = id_q - TX_FIRST;
  assign rx_off = id_q - RX_FIRST;
  assign is_tx  = (id_q >= TX_FIRST) && (tx_off < ID_W'(SLOTS));
  assign is_rx  = (id_q >= RX_FIRST) && (rx_off < ID_W'(SLOTS));
  assign id_ok  = is_tx || is_rx;

  assign addr = ctrl.sweep_sel ? {1'b1, cnt}
              : {is_tx, (is_tx ? tx_off[SLOT_W-1:0] : rx_off[SLOT_W-1:0])};

  assign cur_len  = slot_len[addr];
  assign cur_link = slot_link[addr];
  assign ram_wr   = ctrl.store_wr && id_ok;
  assign read_ok  = (cur_len != '0) && (msg_len_q <= cur_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_len[i]  <= '0;
        slot_link[i] <= LINK_CAN2;
      end
    end else if (ram_wr) begin
      slot_len[addr]  <= msg_len_q;
      slot_link[addr] <= link_q;
    end else if (ctrl.clear_wr && id_ok) begin
      slot_len[addr] <= '0;
    end
  end

  // Bytes past the stored length are written as zero, so unread tails stay clean.
  cmt_ram #(
    .WIDTH(DATA_W),
    .DEPTH(ENTRIES)
  ) u_bytes (
    .clk    (clk),
    .wr_en  (ram_wr),
    .wr_addr(addr),
    .wr_data(payload_q & byte_mask(msg_len_q)),
    .rd_addr(addr),
    .rd_data(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.cnt_clear) begin
      cnt <= '0;
    end else if (ctrl.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign stat.req      = req_q;
  assign stat.eligible = (cur_len != '0) && (cur_len <= FRAME_MAX)
                         && ((cur_link == LINK_CAN1) || (cur_link == LINK_CAN2));
  assign stat.cnt_last = (cnt == SLOT_W'(SLOTS - 1));
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_ack || ctrl.load_read || ctrl.load_frame || ctrl.load_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_ack || ctrl.load_read || ctrl.load_frame || ctrl.load_end) begin
      out_status <= ST_OK;
      out_fid    <= '0;
      out_flen   <= '0;
      out_bus    <= 1'b0;
      out_data   <= '0;
      out_last   <= 1'b1;
      if (ctrl.load_ack) begin
        out_kind   <= (req_q == REQ_STORE) ? KIND_STORE_ACK : KIND_CLEAR_ACK;
        out_status <= id_ok ? ST_OK : ST_BAD_ID;
      end else if (ctrl.load_read) begin
        out_kind <= KIND_READ_REPLY;
        if (!id_ok) begin
          out_status <= ST_BAD_ID;
        end else if (!read_ok) begin
          out_status <= ST_SHORT;
        end else begin
          out_data <= ram_q & byte_mask(msg_len_q);
        end
      end else if (ctrl.load_frame) begin
        out_kind <= KIND_FRAME;
        out_fid  <= TX_FIRST + ID_W'(cnt);
        out_flen <= cur_len[FLEN_W-1:0];
        out_bus  <= cur_link[0];
        out_data <= ram_q & byte_mask(cur_len);
        out_last <= 1'b0;
      end else begin
        out_kind <= KIND_SWEEP_END;
      end
    end
  end

  assign out_tdata = {6'b0, out_data, out_bus, out_flen, out_fid, out_status};
  assign out_tuser = out_kind;

endmodule

>>> design/can_mailbox_table.sv
// ----------------------------------------------------------------------------
// can_mailbox_table
// Two banks of message slots (receive and transmit) with store, read, clear
// and a transmit sweep that emits one frame per sendable slot.
// ----------------------------------------------------------------------------
// Usage: a request word enters on the s_axis channel, its kind in tuser.
// Store, read and clear each return one word on m_axis with tlast set.
// A send sweep returns one frame word per transmit slot whose length is
// 1 to 8 and whose link is a CAN bus, then a sweep-end word with tlast.
// A store or clear result is loaded into the output register from the
// execute state, and a read result from a separate read state, since
// the slot bytes come out of a RAM with a registered read. A sweep visits
// each transmit slot in an address state and then a check-and-emit state,
// and after the last slot loads its sweep-end word from an end state.
// A new request is taken in the cycle after the previous one has been
// fully issued, even while its last word still sits in the output
// register; the block never takes a new request while one is issuing.
// Reset clears all slot lengths to zero and all links to CAN bus two; the
// byte RAM is not cleared. When the receiver stalls, the sequencer holds
// its place and resumes as soon as the output register frees.
// ----------------------------------------------------------------------------
module can_mailbox_table
  import cmt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // msg_id[10:0], msg_len[18:11], link_type[20:19], payload[84:21], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // status[1:0], frame_id[12:2], frame_len[16:13], frame_bus[17],
  // out_data[81:18], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // result_kind[2:0]
  output logic [2:0]             m_axis_tuser,
  output logic                   m_axis_tlast
);

  ctrl_t ctrl;
  stat_t stat;

  cmt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  cmt_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .stat     (stat),
    .in_tdata (s_axis_tdata),
    .in_tuser (s_axis_tuser),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_tdata(m_axis_tdata),
    .out_tuser(m_axis_tuser),
    .out_last (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // The block works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while the previous one was still issuing");

  // Only the sweep-end word closes a sweep; frames never carry tlast.
  a_frame_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == KIND_FRAME)) |-> !m_axis_tlast)
    else $error("frame word marked as last");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == KIND_SWEEP_END)) |-> m_axis_tlast)
    else $error("sweep-end word without tlast");

  // A sent frame always has a length of one to eight bytes.
  a_frame_len: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == KIND_FRAME))
      |-> ((m_axis_tdata[16:13] != 4'd0) && (m_axis_tdata[16:13] <= 4'd8)))
    else $error("frame length out of range");
`endif

endmodule
